// ----- rtl/tab_normalizer_stream_core_macros.svh -----
// assertion macros shared by the rtl of the tab normaliser
`ifndef TAB_NORMALIZER_STREAM_CORE_MACROS_SVH
`define TAB_NORMALIZER_STREAM_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define TNS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TNS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_pkg
// Shared widths and character codes for the tab normaliser.
// ----------------------------------------------------------------------------
package tns_pkg;

	localparam int CHAR_W        = 8;
	localparam int CFG_W         = 5;
	localparam int TAB_WIDTH_RST = 8;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

endpackage

// ----- rtl/tab_normalizer_stream_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_normalizer_stream_core
// Re-tabs a stream of text bytes with a configurable tab stop width.
// ----------------------------------------------------------------------------
// One text byte is accepted a cycle while in_stall is low. A byte that
// flushes held spaces yields up to MAX_TAB_WIDTH bytes, which the back end
// sends one a cycle while out_stall is low, so the output port sets the
// long-run rate. A four-entry command queue lets the front end keep taking
// bytes while the back end expands a flush. After a tab_width write the
// column is brought below the new width by repeated subtraction, during
// which no byte is accepted. Spaces still held when the stream ends are
// never sent.

module tab_normalizer_stream_core #(
	parameter int MAX_TAB_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tns_pkg::CHAR_W-1:0] in_char,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tns_pkg::CHAR_W-1:0] out_char,
	output logic                       last,
	input  logic                       tab_width_we,
	input  logic [tns_pkg::CFG_W-1:0]  tab_width
);
	import tns_pkg::*;

	localparam int PW    = $clog2(MAX_TAB_WIDTH);
	localparam int CMD_W = 1 + PW + CHAR_W;
	localparam int QUEUE_DEPTH = 4;

	logic              q_full;
	logic              push;
	logic              push_lead_tab;
	logic [PW-1:0]     push_lead_cnt;
	logic [CHAR_W-1:0] push_char;
	logic              pop;
	logic              head_valid;
	logic [CMD_W-1:0]  head_data;

	tns_front #(
		.MAX_TAB_WIDTH(MAX_TAB_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_char      (in_char),
		.tab_width_we (tab_width_we),
		.tab_width    (tab_width),
		.q_full       (q_full),
		.push         (push),
		.push_lead_tab(push_lead_tab),
		.push_lead_cnt(push_lead_cnt),
		.push_char    (push_char)
	);

	tns_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(CMD_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_lead_tab, push_lead_cnt, push_char}),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	tns_back #(
		.MAX_TAB_WIDTH(MAX_TAB_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_lead_tab(head_data[CMD_W-1]),
		.head_lead_cnt(head_data[CHAR_W +: PW]),
		.head_char    (head_data[CHAR_W-1:0]),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last         (last)
	);

endmodule

// ----- rtl/tns_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_front
// Takes text bytes, tracks the column within the tab stop and the held
// spaces, and queues one output command per byte that gives output.
// ----------------------------------------------------------------------------
`include "tab_normalizer_stream_core_macros.svh"

module tns_front #(
	parameter int MAX_TAB_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [tns_pkg::CHAR_W-1:0] in_char,
	input  logic                      tab_width_we,
	input  logic [tns_pkg::CFG_W-1:0] tab_width,
	input  logic                      q_full,
	output logic                      push,
	output logic                      push_lead_tab,
	output logic [$clog2(MAX_TAB_WIDTH)-1:0] push_lead_cnt,
	output logic [tns_pkg::CHAR_W-1:0] push_char
);
	import tns_pkg::*;

	localparam int PW = $clog2(MAX_TAB_WIDTH);
	localparam int EW = $clog2(MAX_TAB_WIDTH + 1);
	localparam int CW = (EW > CFG_W) ? EW : CFG_W;
	localparam int W_RST = (TAB_WIDTH_RST > MAX_TAB_WIDTH) ? MAX_TAB_WIDTH : TAB_WIDTH_RST;
	localparam logic [CW-1:0] MAX_CW   = CW'(MAX_TAB_WIDTH);
	localparam logic [PW-1:0] HELD_SAT = PW'(MAX_TAB_WIDTH - 1);

	logic [EW-1:0] width_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] held_q;

	logic          accept;
	logic          reducing;
	logic          last_col;
	logic          is_tab;
	logic          is_space;
	logic [EW-1:0] pos_ext;
	logic [CW-1:0] tw_ext;
	logic [EW-1:0] width_new;
	logic [PW-1:0] pos_inc;

	assign pos_ext  = EW'(pos_q);
	assign reducing = (pos_ext >= width_q);
	assign last_col = (pos_ext == (width_q - EW'(1)));
	assign pos_inc  = last_col ? '0 : (pos_q + PW'(1));
	assign is_tab   = (in_char == CH_TAB);
	assign is_space = (in_char == CH_SPACE);

	// the stored column is brought below a new width one subtraction a cycle
	assign in_stall = q_full || reducing;
	assign accept   = in_valid && !in_stall;

	assign tw_ext = CW'(tab_width);
	always_comb begin
		priority if (tw_ext == '0) begin
			width_new = EW'(1);
		end else if (tw_ext > MAX_CW) begin
			width_new = EW'(MAX_TAB_WIDTH);
		end else begin
			width_new = EW'(tw_ext);
		end
	end

	always_comb begin
		push          = 1'b0;
		push_lead_tab = 1'b0;
		push_lead_cnt = '0;
		push_char     = in_char;
		priority if (is_tab) begin
			push      = accept;
			push_char = CH_TAB;
		end else if (is_space) begin
			push      = accept && last_col;
			push_char = CH_TAB;
		end else begin
			push = accept;
			if (held_q != '0) begin
				// held spaces that end on a stop boundary become one tab
				push_lead_tab = (pos_q == '0);
				push_lead_cnt = (pos_q == '0) ? PW'(1) : held_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= EW'(W_RST);
			pos_q   <= '0;
			held_q  <= '0;
		end else begin
			if (tab_width_we) begin
				width_q <= width_new;
			end
			if (reducing) begin
				pos_q <= PW'(pos_ext - width_q);
			end else if (accept) begin
				priority if (is_tab) begin
					pos_q  <= '0;
					held_q <= '0;
				end else if (is_space) begin
					if (last_col) begin
						pos_q  <= '0;
						held_q <= '0;
					end else begin
						pos_q <= pos_q + PW'(1);
						if (held_q != HELD_SAT) begin
							held_q <= held_q + PW'(1);
						end
					end
				end else begin
					held_q <= '0;
					pos_q  <= (in_char == CH_NL) ? '0 : pos_inc;
				end
			end
		end
	end

	`TNS_ASSERT_ALWAYS(a_width_range, clk, arst_n,
		(width_q != '0) && (width_q <= EW'(MAX_TAB_WIDTH)), "tab width out of range")
	`TNS_ASSERT_ALWAYS(a_push_on_accept, clk, arst_n, !push || accept,
		"command queued without an accepted request")
	`TNS_ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && q_full),
		"command queued into a full queue")
	`TNS_ASSERT_ALWAYS(a_accept_in_stop, clk, arst_n, !accept || (pos_ext < width_q),
		"request accepted with column beyond the stop")

endmodule

// ----- rtl/tns_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_fifo
// Short command queue between the front and back ends, head shown ahead.
// ----------------------------------------------------------------------------
`include "tab_normalizer_stream_core_macros.svh"

module tns_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`TNS_ASSERT_ALWAYS(a_fifo_overflow, clk, arst_n, !(push && full), "push into full queue")
	`TNS_ASSERT_ALWAYS(a_fifo_underflow, clk, arst_n, !(pop && !head_valid),
		"pop from empty queue")
	`TNS_ASSERT_ALWAYS(a_fifo_count, clk, arst_n, count_q <= NW'(DEPTH),
		"queue count beyond depth")

endmodule

// ----- rtl/tns_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_back
// Expands queued commands into output bytes: the leading spaces or tab,
// then the byte itself flagged as last, through one output register.
// ----------------------------------------------------------------------------
`include "tab_normalizer_stream_core_macros.svh"

module tns_back #(
	parameter int MAX_TAB_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  logic                       head_lead_tab,
	input  logic [$clog2(MAX_TAB_WIDTH)-1:0] head_lead_cnt,
	input  logic [tns_pkg::CHAR_W-1:0] head_char,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tns_pkg::CHAR_W-1:0] out_char,
	output logic                       last
);
	import tns_pkg::*;

	localparam int PW = $clog2(MAX_TAB_WIDTH);

	logic [PW-1:0]     lead_done_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_q;
	logic              advance;
	logic              emit_final;

	assign advance    = !out_valid_q || !out_stall;
	assign emit_final = (lead_done_q == head_lead_cnt);
	assign pop        = advance && head_valid && emit_final;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lead_done_q <= '0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (emit_final) begin
					lead_done_q <= '0;
				end else begin
					lead_done_q <= lead_done_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			if (emit_final) begin
				out_char_q <= head_char;
				last_q     <= 1'b1;
			end else begin
				out_char_q <= head_lead_tab ? CH_TAB : CH_SPACE;
				last_q     <= 1'b0;
			end
		end
	end

	`TNS_ASSERT_ALWAYS(a_lead_bound, clk, arst_n, !head_valid || (lead_done_q <= head_lead_cnt),
		"leading count ran past its command")
	`TNS_ASSERT_ALWAYS(a_idle_count, clk, arst_n, head_valid || (lead_done_q == '0),
		"leading count left over with no command")
	`TNS_ASSERT_ALWAYS(a_pop_last, clk, arst_n, !$past(pop) || (out_valid_q && last_q),
		"command retired without a last byte")

endmodule

// ----- tb/tab_normalizer_stream_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_normalizer_stream_core_tb
// Self-checking bench for the tab normaliser: a table of directed requests
// and then phases of random text at different tab widths, each accepted
// request is run through a local re-tab model and every output byte is
// compared with the oldest predicted one. Both ports idle and stall at random.
// ----------------------------------------------------------------------------

module tab_normalizer_stream_core_tb;

	import tns_pkg::*;

	localparam int MAX_TAB_W  = 16;
	localparam int SETTLE_CYC = 32;
	localparam int RAND_ITEMS = 84;
	localparam int RAND_PHASES = 6;

	typedef enum logic {ROW_BYTE, ROW_WIDTH} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CHAR_W-1:0] value;
		int unsigned       reps;
		bit                typed;
		logic [CHAR_W-1:0] exp_char;
	} dir_row_t;

	typedef struct {
		bit                typed;
		logic [CHAR_W-1:0] exp_char;
	} req_note_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} out_beat_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [CHAR_W-1:0] in_char      = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic              last;
	logic              tab_width_we = 1'b0;
	logic [CFG_W-1:0]  tab_width    = CFG_W'(TAB_WIDTH_RST);

	// model state, owned by the monitor process
	logic [CFG_W-1:0]  width_reg = CFG_W'(TAB_WIDTH_RST);
	logic [3:0]        col       = '0;
	logic [3:0]        held      = '0;

	req_note_t         req_notes[$];
	out_beat_t         expected_bytes[$];
	dir_row_t          dir_rows[18];
	int                fail_cnt  = 0;
	bit                steady    = 1'b0;

	tab_normalizer_stream_core #(
		.MAX_TAB_WIDTH(MAX_TAB_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_char     (in_char),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last        (last),
		.tab_width_we(tab_width_we),
		.tab_width   (tab_width)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%t %s", $realtime, msg);
		end
	endtask

	// re-tab one accepted byte and queue the bytes it should produce
	task automatic retab_predict(input logic [CHAR_W-1:0] c, input req_note_t note);
		int unsigned       w;
		int unsigned       p;
		logic [CHAR_W-1:0] beats[$];
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_TAB_W) ? MAX_TAB_W : width_reg);
		p = col % w;
		if (c == CH_TAB) begin
			beats.push_back(CH_TAB);
			held = '0;
			p = 0;
		end else if (c == CH_SPACE) begin
			if (p == w - 1) begin
				beats.push_back(CH_TAB);
				held = '0;
				p = 0;
			end else begin
				if (held < MAX_TAB_W - 1) held++;
				p++;
			end
		end else begin
			if (held != 0) begin
				// spaces held across a stop boundary collapse into one tab
				if (p == 0) beats.push_back(CH_TAB);
				else repeat (held) beats.push_back(CH_SPACE);
				held = '0;
			end
			beats.push_back(c);
			if (c == CH_NL || p == w - 1) p = 0;
			else p++;
		end
		col = p[3:0];
		if (note.typed) begin
			expected_bytes.push_back('{note.exp_char, 1'b1});
		end else begin
			foreach (beats[i]) expected_bytes.push_back('{beats[i], i == beats.size() - 1});
		end
	endtask

	// input side, config writes and output checks share one process so ordering is fixed
	always @(posedge clk) begin
		out_beat_t exp_beat;
		if (arst_n) begin
			if (tab_width_we) width_reg = tab_width;
			if (in_valid && !in_stall) retab_predict(in_char, req_notes.pop_front());
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					note_fail($sformatf("unexpected output byte %02h last %0d", out_char, last));
				end else begin
					exp_beat = expected_bytes.pop_front();
					if (out_char !== exp_beat.ch)
						note_fail($sformatf("out_char mismatch: expected %02h actual %02h",
							exp_beat.ch, out_char));
					if (last !== exp_beat.last)
						note_fail($sformatf("last mismatch on %02h: expected %0d actual %0d",
							exp_beat.ch, exp_beat.last, last));
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 23);
	end

	task automatic send_byte(input logic [CHAR_W-1:0] c, input bit typed,
		input logic [CHAR_W-1:0] exp_char);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req_notes.push_back('{typed, exp_char});
		in_valid <= 1'b1;
		in_char  <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// sender waits out every pending result, then lets queued no-output requests drain
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (req_notes.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_width(input logic [CFG_W-1:0] v);
		drain_all();
		tab_width_we <= 1'b1;
		tab_width    <= v;
		@(posedge clk);
		tab_width_we <= 1'b0;
	endtask

	initial begin
		logic [CHAR_W-1:0] c;
		logic [CFG_W-1:0]  w;
		int unsigned       roll;

		dir_rows = '{
			'{ROW_BYTE,  8'h41,    1,  1'b1, 8'h41},
			'{ROW_BYTE,  8'h00,    1,  1'b1, 8'h00},
			'{ROW_BYTE,  8'hff,    1,  1'b1, 8'hff},
			'{ROW_BYTE,  CH_SPACE, 1,  1'b0, 8'h00},
			'{ROW_BYTE,  CH_TAB,   1,  1'b1, CH_TAB},   // tab drops the held space
			'{ROW_BYTE,  CH_SPACE, 2,  1'b0, 8'h00},
			'{ROW_WIDTH, 8'd2,     1,  1'b0, 8'h00},    // column wraps on width change
			'{ROW_BYTE,  8'h7a,    1,  1'b0, 8'h00},    // held spaces at a stop give a tab
			'{ROW_BYTE,  CH_SPACE, 1,  1'b1, CH_TAB},   // space on the last column
			'{ROW_BYTE,  CH_NL,    1,  1'b1, CH_NL},
			'{ROW_WIDTH, 8'd0,     1,  1'b0, 8'h00},    // zero width acts as one
			'{ROW_BYTE,  8'h6b,    1,  1'b1, 8'h6b},
			'{ROW_BYTE,  CH_SPACE, 1,  1'b1, CH_TAB},
			'{ROW_WIDTH, 8'd31,    1,  1'b0, 8'h00},    // clamped to the maximum width
			'{ROW_BYTE,  CH_SPACE, 15, 1'b0, 8'h00},
			'{ROW_WIDTH, 8'd15,    1,  1'b0, 8'h00},
			'{ROW_BYTE,  CH_SPACE, 1,  1'b0, 8'h00},    // held count saturates
			'{ROW_BYTE,  8'h71,    1,  1'b0, 8'h00}     // longest flush
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WIDTH) begin
				write_width(dir_rows[i].value[CFG_W-1:0]);
			end else begin
				repeat (dir_rows[i].reps)
					send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].exp_char);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					w = 5'd1;
				end
				1: begin
					w = 5'd16;
				end
				2: begin
					w = 5'd0;
				end
				3: begin
					w = 5'd31;
				end
				default: begin
					w = CFG_W'($urandom_range(0, 31));
				end
			endcase
			write_width(w);
			for (int k = 0; k < RAND_ITEMS; k++) begin
				// one long stretch with no idling on either port
				steady = (ph == 2) && (k >= 10) && (k < 75);
				roll = $urandom_range(99);
				if (roll < 40) c = CH_SPACE;
				else if (roll < 48) c = CH_TAB;
				else if (roll < 55) c = CH_NL;
				else if (roll < 60) c = $urandom_range(1) ? 8'hff : 8'h00;
				else c = CHAR_W'($urandom_range(0, 255));
				send_byte(c, 1'b0, 8'h00);
			end
			steady = 1'b0;
		end

		drain_all();
		if (fail_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
